/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the stroke core checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property, disabled while reset is low
`define CRB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// assert a property at every edge, reset included
`define CRB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`endif

/* rtl/crb_pkg.sv */
// ---------------------------------------------------------------------------
// crb_pkg
// Widths, codes and constants of the Catmull-Rom to Bezier stroke core.
// ---------------------------------------------------------------------------
`default_nettype none

package crb_pkg;

    localparam int PT_W      = 16;            // coordinate field width
    localparam int PRS_W     = 16;
    localparam int TIME_W    = 32;
    localparam int TENS_W    = 16;
    localparam int MIR_W     = PT_W + 2;      // phantom point range
    localparam int DIFF_W    = MIR_W + 1;     // neighbor difference range
    localparam int PROD_W    = DIFF_W + TENS_W + 1;
    localparam int SUM_W     = PT_W + 6;      // anchor plus offset
    localparam int QN_W      = 21;            // rounded magnitude / 8192
    localparam int RCP_W     = 20;
    localparam int GQ_W      = 20;            // offset magnitude
    localparam int RND_SH    = 13;            // 24576 = 3 * 8192
    localparam int RCP_SH    = 21;
    localparam int DATA_W    = 80;
    localparam int ROLE_W    = 2;

    localparam int COORD_WIDTH_DEF = 16;

    localparam logic [TENS_W-1:0] TENSION_RST = 16'd4096;
    localparam logic [PROD_W-1:0] ROUND_BIAS  = PROD_W'(12288);
    localparam logic [RCP_W-1:0]  RECIP3      = RCP_W'(699051); // (2^21+1)/3

    localparam logic [ROLE_W-1:0] ROLE_START = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_CTRL1 = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_CTRL2 = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_END   = 2'd3;

    typedef struct packed {
        logic [ROLE_W-1:0] role;
        logic              last;
        logic [PRS_W-1:0]  pressure;
        logic [TIME_W-1:0] stamp;
    } t_side;

endpackage

`default_nettype wire

/* rtl/crb_coord_pipe.sv */
// ---------------------------------------------------------------------------
// crb_coord_pipe
// Five-stage pipeline for one coordinate: anchor + round(diff * tension / 6),
// saturated to COORD_WIDTH bits and trimmed to the field width.
// ---------------------------------------------------------------------------
`default_nettype none

module crb_coord_pipe #(
    parameter int COORD_WIDTH = crb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [crb_pkg::PT_W-1:0]    i_anchor,
    input  wire logic signed [crb_pkg::DIFF_W-1:0]  i_diff,
    input  wire logic        [crb_pkg::TENS_W-1:0]  i_tension,
    output logic             [crb_pkg::PT_W-1:0]    o_coord
);

    localparam int EXT_W = (COORD_WIDTH > crb_pkg::SUM_W) ? COORD_WIDTH : crb_pkg::SUM_W;
    localparam logic signed [EXT_W-1:0] SAT_HI =
        EXT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

    logic signed [crb_pkg::PT_W-1:0]   r_anc1, r_anc2, r_anc3, r_anc4;
    logic signed [crb_pkg::DIFF_W-1:0] r_diff;
    logic signed [crb_pkg::PROD_W-1:0] r_prod;
    logic        [crb_pkg::QN_W-1:0]   r_qn;
    logic                              r_neg3, r_neg4;
    logic [crb_pkg::QN_W+crb_pkg::RCP_W-1:0] r_qp;

    logic signed [crb_pkg::TENS_W:0]   ten_s;
    logic signed [crb_pkg::PROD_W-1:0] prod_c;
    logic        [crb_pkg::PROD_W-1:0] mag;
    logic        [crb_pkg::PROD_W-1:0] rnd;
    logic        [crb_pkg::GQ_W-1:0]   q;
    logic signed [crb_pkg::GQ_W:0]     q_s;
    logic signed [crb_pkg::GQ_W:0]     gain;
    logic signed [crb_pkg::SUM_W-1:0]  sum;
    logic signed [EXT_W-1:0]           sum_ext;
    logic signed [EXT_W-1:0]           sat;

    assign ten_s  = $signed({1'b0, i_tension});
    assign prod_c = r_diff * ten_s;
    assign mag    = r_prod[crb_pkg::PROD_W-1] ? crb_pkg::PROD_W'(-r_prod)
                                              : crb_pkg::PROD_W'(r_prod);
    assign rnd    = mag + crb_pkg::ROUND_BIAS;

    assign q       = r_qp[crb_pkg::RCP_SH+crb_pkg::GQ_W-1:crb_pkg::RCP_SH];
    assign q_s     = $signed({1'b0, q});
    assign gain    = r_neg4 ? -q_s : q_s;
    assign sum     = crb_pkg::SUM_W'(r_anc4) + crb_pkg::SUM_W'(gain);
    assign sum_ext = EXT_W'(sum);

    always_comb begin
        if (sum_ext > SAT_HI) begin
            sat = SAT_HI;
        end else if (sum_ext < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = sum_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_anc1  <= i_anchor;
            r_diff  <= i_diff;
            r_anc2  <= r_anc1;
            r_prod  <= prod_c;
            r_anc3  <= r_anc2;
            r_neg3  <= r_prod[crb_pkg::PROD_W-1];
            r_qn    <= rnd[crb_pkg::RND_SH+crb_pkg::QN_W-1:crb_pkg::RND_SH];
            r_anc4  <= r_anc3;
            r_neg4  <= r_neg3;
            r_qp    <= r_qn * crb_pkg::RECIP3;
            o_coord <= sat[crb_pkg::PT_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/catmull_rom_to_bezier_stroke_core.sv */
// Each input word yields 0, 4 or 8 result words, one per cycle when not stalled.
// The next input word is taken in the cycle the last result of the current one
// enters the x and y coordinate pipelines. Reset (synchronous, active low)
// clears the stroke window count, the job busy flag and the pipeline valids,
// and sets tension to 1.0.
// ---------------------------------------------------------------------------
// catmull_rom_to_bezier_stroke_core
// Pen stroke points in, cubic Bezier segments out as four points each.
// ---------------------------------------------------------------------------
`default_nettype none

module catmull_rom_to_bezier_stroke_core #(
    parameter int COORD_WIDTH = crb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [crb_pkg::TENS_W-1:0]    i_cfg_wdata,    // tension
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // point_x[15:0], point_y[31:16], point_pressure[47:32], point_time[79:48]
    input  wire logic [crb_pkg::DATA_W-1:0]    i_s_axis_tdata,
    input  wire logic                          i_s_axis_tlast, // stroke_end
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // out_x[15:0], out_y[31:16], out_pressure[47:32], out_time[79:48]
    output logic [crb_pkg::DATA_W-1:0]         o_m_axis_tdata,
    output logic [crb_pkg::ROLE_W-1:0]         o_m_axis_tuser, // role[1:0]
    output logic                               o_m_axis_tlast  // last_of_run
);

    localparam int PT_W   = crb_pkg::PT_W;
    localparam int MIR_W  = crb_pkg::MIR_W;
    localparam int DIFF_W = crb_pkg::DIFF_W;
    localparam int PRS_W  = crb_pkg::PRS_W;
    localparam int TIME_W = crb_pkg::TIME_W;
    localparam int NSTG   = 5;

    localparam logic [2:0] STEP_ONE_SEG = 3'd3;
    localparam logic [2:0] STEP_TWO_SEG = 3'd7;

    function automatic logic signed [MIR_W-1:0] mirror(
        input logic signed [PT_W-1:0] anchor,
        input logic signed [PT_W-1:0] other
    );
        mirror = (MIR_W'(anchor) <<< 1) - MIR_W'(other);
    endfunction

    logic [crb_pkg::TENS_W-1:0] r_tension;

    // stroke window, oldest first
    logic signed [PT_W-1:0]   r_win_x [3];
    logic signed [PT_W-1:0]   r_win_y [3];
    logic        [PRS_W-1:0]  r_win_p [3];
    logic        [TIME_W-1:0] r_win_t [3];
    logic        [1:0]        r_seen;

    // segment job: five points, pressure and time of the three real anchors
    logic signed [MIR_W-1:0]  r_q_x [5];
    logic signed [MIR_W-1:0]  r_q_y [5];
    logic        [PRS_W-1:0]  r_q_p [3];
    logic        [TIME_W-1:0] r_q_t [3];
    logic                     r_busy;
    logic        [2:0]        r_step;
    logic        [2:0]        r_last_step;

    logic signed [MIR_W-1:0]  n_q_x [5];
    logic signed [MIR_W-1:0]  n_q_y [5];
    logic        [PRS_W-1:0]  n_q_p [3];
    logic        [TIME_W-1:0] n_q_t [3];
    logic                     n_has_job;
    logic        [2:0]        n_last_step;

    logic [NSTG-1:0]      r_vld;
    crb_pkg::t_side       r_sb [NSTG];
    crb_pkg::t_side       n_sb;

    logic signed [PT_W-1:0]   s_x, s_y;
    logic        [PRS_W-1:0]  s_p;
    logic        [TIME_W-1:0] s_t;
    logic                     s_end;
    logic                     s_acc;
    logic                     adv;
    logic                     issue;
    logic                     final_step;

    logic                     seg;
    logic signed [MIR_W-1:0]  pa_x, pb_x, pc_x, pd_x;
    logic signed [MIR_W-1:0]  pa_y, pb_y, pc_y, pd_y;
    logic signed [PT_W-1:0]   anc_x, anc_y;
    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic        [PT_W-1:0]   out_x, out_y;

    assign s_x   = $signed(i_s_axis_tdata[15:0]);
    assign s_y   = $signed(i_s_axis_tdata[31:16]);
    assign s_p   = i_s_axis_tdata[47:32];
    assign s_t   = i_s_axis_tdata[79:48];
    assign s_end = i_s_axis_tlast;

    assign adv        = !r_vld[NSTG-1] || i_m_axis_tready;
    assign issue      = r_busy && adv;
    assign final_step = (r_step == r_last_step);

    assign o_s_axis_tready = !r_busy || (adv && final_step);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // build the job for the incoming point
    always_comb begin
        n_q_x[0] = mirror(r_win_x[1], r_win_x[2]);
        n_q_y[0] = mirror(r_win_y[1], r_win_y[2]);
        n_q_x[1] = MIR_W'(r_win_x[1]);
        n_q_y[1] = MIR_W'(r_win_y[1]);
        n_q_x[2] = MIR_W'(r_win_x[2]);
        n_q_y[2] = MIR_W'(r_win_y[2]);
        n_q_x[3] = MIR_W'(s_x);
        n_q_y[3] = MIR_W'(s_y);
        n_q_x[4] = mirror(s_x, r_win_x[2]);
        n_q_y[4] = mirror(s_y, r_win_y[2]);
        n_q_p[0] = r_win_p[1];
        n_q_t[0] = r_win_t[1];
        n_q_p[1] = r_win_p[2];
        n_q_t[1] = r_win_t[2];
        n_q_p[2] = s_p;
        n_q_t[2] = s_t;
        n_has_job   = (r_seen >= 2'd2) || (r_seen == 2'd1 && s_end);
        n_last_step = (r_seen >= 2'd2 && s_end) ? STEP_TWO_SEG : STEP_ONE_SEG;
        if (r_seen == 2'd3) begin
            n_q_x[0] = MIR_W'(r_win_x[0]);
            n_q_y[0] = MIR_W'(r_win_y[0]);
        end else if (r_seen == 2'd1) begin
            // straight segment between the only two points
            n_q_x[0] = MIR_W'(r_win_x[2]);
            n_q_y[0] = MIR_W'(r_win_y[2]);
            n_q_x[1] = MIR_W'(r_win_x[2]);
            n_q_y[1] = MIR_W'(r_win_y[2]);
            n_q_x[2] = MIR_W'(s_x);
            n_q_y[2] = MIR_W'(s_y);
            n_q_p[0] = r_win_p[2];
            n_q_t[0] = r_win_t[2];
            n_q_p[1] = s_p;
            n_q_t[1] = s_t;
        end
    end

    // select operands for the current step
    assign seg  = r_step[2];
    assign pa_x = seg ? r_q_x[1] : r_q_x[0];
    assign pb_x = seg ? r_q_x[2] : r_q_x[1];
    assign pc_x = seg ? r_q_x[3] : r_q_x[2];
    assign pd_x = seg ? r_q_x[4] : r_q_x[3];
    assign pa_y = seg ? r_q_y[1] : r_q_y[0];
    assign pb_y = seg ? r_q_y[2] : r_q_y[1];
    assign pc_y = seg ? r_q_y[3] : r_q_y[2];
    assign pd_y = seg ? r_q_y[4] : r_q_y[3];

    always_comb begin
        anc_x = pb_x[PT_W-1:0];
        anc_y = pb_y[PT_W-1:0];
        diff_x = '0;
        diff_y = '0;
        n_sb.role     = r_step[1:0];
        n_sb.last     = final_step;
        n_sb.pressure = seg ? r_q_p[1] : r_q_p[0];
        n_sb.stamp    = seg ? r_q_t[1] : r_q_t[0];
        unique case (r_step[1:0])
            crb_pkg::ROLE_START: begin
            end
            crb_pkg::ROLE_CTRL1: begin
                diff_x = DIFF_W'(pc_x) - DIFF_W'(pa_x);
                diff_y = DIFF_W'(pc_y) - DIFF_W'(pa_y);
            end
            crb_pkg::ROLE_CTRL2: begin
                anc_x  = pc_x[PT_W-1:0];
                anc_y  = pc_y[PT_W-1:0];
                diff_x = DIFF_W'(pb_x) - DIFF_W'(pd_x);
                diff_y = DIFF_W'(pb_y) - DIFF_W'(pd_y);
                n_sb.pressure = seg ? r_q_p[2] : r_q_p[1];
                n_sb.stamp    = seg ? r_q_t[2] : r_q_t[1];
            end
            crb_pkg::ROLE_END: begin
                anc_x  = pc_x[PT_W-1:0];
                anc_y  = pc_y[PT_W-1:0];
                n_sb.pressure = seg ? r_q_p[2] : r_q_p[1];
                n_sb.stamp    = seg ? r_q_t[2] : r_q_t[1];
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension   <= crb_pkg::TENSION_RST;
            r_seen      <= '0;
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_last_step <= STEP_ONE_SEG;
            r_vld       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tension <= i_cfg_wdata;
            end
            if (s_acc) begin
                if (s_end) begin
                    r_seen <= '0;
                end else if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
            if (s_acc && n_has_job) begin
                r_busy      <= 1'b1;
                r_step      <= '0;
                r_last_step <= n_last_step;
            end else if (issue) begin
                if (final_step) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
            if (adv) begin
                r_vld <= {r_vld[NSTG-2:0], issue};
            end
        end
    end

    // window, job and side-band payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_win_x[0] <= r_win_x[1];
            r_win_y[0] <= r_win_y[1];
            r_win_p[0] <= r_win_p[1];
            r_win_t[0] <= r_win_t[1];
            r_win_x[1] <= r_win_x[2];
            r_win_y[1] <= r_win_y[2];
            r_win_p[1] <= r_win_p[2];
            r_win_t[1] <= r_win_t[2];
            r_win_x[2] <= s_x;
            r_win_y[2] <= s_y;
            r_win_p[2] <= s_p;
            r_win_t[2] <= s_t;
            if (n_has_job) begin
                r_q_x <= n_q_x;
                r_q_y <= n_q_y;
                r_q_p <= n_q_p;
                r_q_t <= n_q_t;
            end
        end
        if (adv) begin
            r_sb[0] <= n_sb;
            for (int i = 1; i < NSTG; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    crb_coord_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_pipe_x (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_anchor  (anc_x),
        .i_diff    (diff_x),
        .i_tension (r_tension),
        .o_coord   (out_x)
    );

    crb_coord_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_pipe_y (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_anchor  (anc_y),
        .i_diff    (diff_y),
        .i_tension (r_tension),
        .o_coord   (out_y)
    );

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {r_sb[NSTG-1].stamp, r_sb[NSTG-1].pressure, out_y, out_x};
    assign o_m_axis_tuser  = r_sb[NSTG-1].role;
    assign o_m_axis_tlast  = r_sb[NSTG-1].last;

endmodule

`default_nettype wire

/* rtl/crb_checker.sv */
// ---------------------------------------------------------------------------
// crb_checker
// Port-level checks of the stroke core output stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [crb_pkg::DATA_W-1:0]    o_m_axis_tdata,
    input wire logic [crb_pkg::ROLE_W-1:0]    o_m_axis_tuser,
    input wire logic                          o_m_axis_tlast
);

    logic m_stall;
    logic m_acc;

    assign m_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_acc   = o_m_axis_tvalid && i_m_axis_tready;

    `CRB_ASSERT(a_out_hold, i_clk, i_rst_n, m_stall |=> o_m_axis_tvalid)
    `CRB_ASSERT(a_out_stable, i_clk, i_rst_n,
        m_stall |=> ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
    `CRB_ASSERT(a_last_on_end, i_clk, i_rst_n,
        (m_acc && o_m_axis_tlast) |-> (o_m_axis_tuser == crb_pkg::ROLE_END))
    `CRB_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind catmull_rom_to_bezier_stroke_core crb_checker u_crb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives pen stroke words into the Catmull-Rom to Bezier stroke core, predicts
// every emitted Bezier point from its own stroke window and tension copy, and
// checks each output word field by field. The run covers directed strokes
// (single point, two points, three points, extremes) and random strokes under
// several tension settings and sender/receiver idle patterns.
// ---------------------------------------------------------------------------

module testbench;

    typedef struct {
        longint           x;
        longint           y;
        logic [15:0]      pressure;
        logic [31:0]      stamp;
    } t_anchor;

    typedef struct {
        logic [15:0]                x;
        logic [15:0]                y;
        logic [15:0]                pressure;
        logic [31:0]                stamp;
        logic [crb_pkg::ROLE_W-1:0] role;
        logic                       is_last;
    } t_bezier_pt;

    typedef struct {
        logic [crb_pkg::DATA_W-1:0] data;
        logic                       stroke_end;
    } t_pen_word;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [crb_pkg::TENS_W-1:0]   i_cfg_wdata = '0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [crb_pkg::DATA_W-1:0]   i_s_axis_tdata = '0;
    logic                         i_s_axis_tlast = 1'b0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [crb_pkg::DATA_W-1:0]   o_m_axis_tdata;
    logic [crb_pkg::ROLE_W-1:0]   o_m_axis_tuser;
    logic                         o_m_axis_tlast;

    catmull_rom_to_bezier_stroke_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // point_x, point_y, point_pressure, point_time
        .i_s_axis_tlast  (i_s_axis_tlast),  // stroke_end
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // out_x, out_y, out_pressure, out_time
        .o_m_axis_tuser  (o_m_axis_tuser),  // role
        .o_m_axis_tlast  (o_m_axis_tlast)   // last_of_run
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_pen_word   pen_word_q[$];
    t_bezier_pt  bezier_pt_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_count = 0;

    // predictor copy of the block state
    logic [crb_pkg::TENS_W-1:0] tension_cur = crb_pkg::TENSION_RST;
    t_anchor                    stroke_win[3];
    int                         pts_seen = 0;

    function automatic logic [15:0] clamp_coord(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint ctrl_offset(longint diff);
        longint num, mag, q;
        num = diff * longint'(tension_cur);
        mag = (num < 0) ? -num : num;
        q   = (mag + 12288) / 24576;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_anchor mirror_pt(t_anchor anchor, t_anchor other);
        t_anchor r;
        r   = anchor;
        r.x = 2 * anchor.x - other.x;
        r.y = 2 * anchor.y - other.y;
        return r;
    endfunction

    function automatic void push_point(longint x, longint y, t_anchor src,
                                       logic [crb_pkg::ROLE_W-1:0] role);
        t_bezier_pt p;
        p.x        = clamp_coord(x);
        p.y        = clamp_coord(y);
        p.pressure = src.pressure;
        p.stamp    = src.stamp;
        p.role     = role;
        p.is_last  = 1'b0;
        bezier_pt_q.insert(bezier_pt_q.size(), p);
    endfunction

    function automatic void push_segment(t_anchor a, t_anchor b, t_anchor c, t_anchor d);
        push_point(b.x, b.y, b, crb_pkg::ROLE_START);
        push_point(b.x + ctrl_offset(c.x - a.x), b.y + ctrl_offset(c.y - a.y), b,
                   crb_pkg::ROLE_CTRL1);
        push_point(c.x - ctrl_offset(d.x - b.x), c.y - ctrl_offset(d.y - b.y), c,
                   crb_pkg::ROLE_CTRL2);
        push_point(c.x, c.y, c, crb_pkg::ROLE_END);
    endfunction

    function automatic void advance_stroke(logic [crb_pkg::DATA_W-1:0] data, logic fin);
        t_anchor s;
        int      n0;
        n0         = bezier_pt_q.size();
        s.x        = longint'($signed(data[15:0]));
        s.y        = longint'($signed(data[31:16]));
        s.pressure = data[47:32];
        s.stamp    = data[79:48];

        if (pts_seen == 1 && fin) begin
            push_segment(stroke_win[2], stroke_win[2], s, s);
        end else if (pts_seen == 2) begin
            push_segment(mirror_pt(stroke_win[1], stroke_win[2]), stroke_win[1],
                         stroke_win[2], s);
            if (fin) begin
                push_segment(stroke_win[1], stroke_win[2], s, mirror_pt(s, stroke_win[2]));
            end
        end else if (pts_seen >= 3) begin
            push_segment(stroke_win[0], stroke_win[1], stroke_win[2], s);
            if (fin) begin
                push_segment(stroke_win[1], stroke_win[2], s, mirror_pt(s, stroke_win[2]));
            end
        end

        if (fin) begin
            for (int i = 0; i < 3; i++) stroke_win[i] = '{0, 0, '0, '0};
            pts_seen = 0;
        end else begin
            stroke_win[0] = stroke_win[1];
            stroke_win[1] = stroke_win[2];
            stroke_win[2] = s;
            if (pts_seen < 3) pts_seen++;
        end

        if (bezier_pt_q.size() > n0) bezier_pt_q[bezier_pt_q.size() - 1].is_last = 1'b1;
    endfunction

    // driver: hold a word until taken, then advance or idle
    always @(posedge i_clk) begin
        t_pen_word w;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                advance_stroke(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pen_word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    w = pen_word_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= w.data;
                    i_s_axis_tlast  <= w.stroke_end;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result word with the oldest expected point
    always @(posedge i_clk) begin
        t_bezier_pt e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (bezier_pt_q.size() == 0) begin
                    $error("unexpected result word: tdata %h role %0d",
                           o_m_axis_tdata, o_m_axis_tuser);
                    err_count++;
                end else begin
                    e = bezier_pt_q.pop_front();
                    if (o_m_axis_tdata[15:0] !== e.x) begin
                        $error("out_x: expected %h, got %h", e.x, o_m_axis_tdata[15:0]);
                        err_count++;
                    end
                    if (o_m_axis_tdata[31:16] !== e.y) begin
                        $error("out_y: expected %h, got %h", e.y, o_m_axis_tdata[31:16]);
                        err_count++;
                    end
                    if (o_m_axis_tdata[47:32] !== e.pressure) begin
                        $error("out_pressure: expected %h, got %h", e.pressure,
                               o_m_axis_tdata[47:32]);
                        err_count++;
                    end
                    if (o_m_axis_tdata[79:48] !== e.stamp) begin
                        $error("out_time: expected %h, got %h", e.stamp,
                               o_m_axis_tdata[79:48]);
                        err_count++;
                    end
                    if (o_m_axis_tuser !== e.role) begin
                        $error("role: expected %0d, got %0d", e.role, o_m_axis_tuser);
                        err_count++;
                    end
                    if (o_m_axis_tlast !== e.is_last) begin
                        $error("last_of_run: expected %0d, got %0d", e.is_last,
                               o_m_axis_tlast);
                        err_count++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void queue_word(logic [15:0] x, logic [15:0] y, logic [15:0] p,
                                       logic [31:0] t, logic fin);
        t_pen_word w;
        w.data       = {t, p, y, x};
        w.stroke_end = fin;
        pen_word_q.insert(pen_word_q.size(), w);
    endfunction

    function automatic logic [15:0] wild_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] wild_pressure();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // returns the number of words queued
    function automatic int queue_stroke();
        int          len;
        bit          smooth, fin;
        logic [15:0] x, y;
        logic [31:0] t;
        len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
        smooth = $urandom_range(0, 2) != 0;
        fin    = $urandom_range(0, 19) != 0;
        x      = wild_coord();
        y      = wild_coord();
        t      = $urandom;
        for (int i = 0; i < len; i++) begin
            if (smooth) begin
                x = x + 16'($urandom_range(0, 1023)) - 16'd512;
                y = y + 16'($urandom_range(0, 1023)) - 16'd512;
                t = t + $urandom_range(1, 200);
            end else begin
                x = wild_coord();
                y = wild_coord();
                t = $urandom;
            end
            queue_word(x, y, wild_pressure(), t, fin && (i == len - 1));
        end
        return len;
    endfunction

    // sample at the falling edge so that all driver updates have settled
    task automatic wait_drained();
        while (!(pen_word_q.size() == 0 && !i_s_axis_tvalid && bezier_pt_q.size() == 0))
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_tension(logic [crb_pkg::TENS_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        tension_cur = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [crb_pkg::TENS_W-1:0] tension_set[6];
        int                         queued;

        tension_set = '{16'hffff, 16'h0000, 16'($urandom), 16'd24576, 16'd1,
                        16'($urandom)};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-point stroke
        queue_word(16'd100, -16'sd200, 16'h1234, 32'd5, 1'b1);
        // two-point stroke, extremes
        queue_word(16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0);
        queue_word(16'h7fff, 16'h8000, 16'hffff, 32'hffffffff, 1'b1);
        // three-point stroke with saturating phantom points
        queue_word(16'h8000, 16'h7fff, 16'h0000, 32'd1, 1'b0);
        queue_word(16'h7fff, 16'h8000, 16'hffff, 32'd2, 1'b0);
        queue_word(16'h0000, 16'h0000, 16'h8000, 32'd3, 1'b1);
        // smooth six-point stroke
        for (int i = 0; i < 6; i++)
            queue_word(16'(i * 37 - 90), 16'(i * i * 11), 16'(i * 9000), 32'(i * 10 + 100),
                       i == 5);
        // alternating extremes, full window
        for (int i = 0; i < 5; i++)
            queue_word(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff,
                       i[0] ? 16'hffff : 16'h0000, i[0] ? 32'hffffffff : 32'h0, i == 4);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            write_tension(tension_set[ph]);
            queued = 0;
            while (queued < 70) queued += queue_stroke();
            wait_drained();
        end

        if (err_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
